@@ hw/rtl/cct_pkg.sv @@
// Shared types, constants and month-length function for the calendar clock.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cct_pkg;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  localparam logic [5:0]  SEC_MAX   = 6'd59;
  localparam logic [5:0]  MIN_MAX   = 6'd59;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [3:0]  MONTH_MIN = 4'd1;
  localparam logic [3:0]  MONTH_MAX = 4'd12;
  localparam logic [4:0]  DAY_MIN   = 5'd1;

  localparam logic [4:0]  DAYS_LONG     = 5'd31;
  localparam logic [4:0]  DAYS_SHORT    = 5'd30;
  localparam logic [4:0]  DAYS_FEB      = 5'd28;
  localparam logic [4:0]  DAYS_FEB_LEAP = 5'd29;

  localparam logic [3:0]  MON_FEB = 4'd2;
  localparam logic [3:0]  MON_APR = 4'd4;
  localparam logic [3:0]  MON_JUN = 4'd6;
  localparam logic [3:0]  MON_SEP = 4'd9;
  localparam logic [3:0]  MON_NOV = 4'd11;

  localparam logic [15:0] YEAR_RST  = 16'd2017;
  localparam logic [3:0]  MONTH_RST = 4'd12;
  localparam logic [4:0]  DAY_RST   = 5'd31;

  typedef struct packed {
    logic        action;
    logic [15:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;
  } item_t;

  typedef struct packed {
    logic [15:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic        load_rejected;
  } result_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = DAYS_LONG;
    if (month == MON_FEB) begin
      len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
    end else if (month == MON_APR || month == MON_JUN ||
                 month == MON_SEP || month == MON_NOV) begin
      len = DAYS_SHORT;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cct_leap.sv @@
// Gregorian leap-year test on a 16-bit year.
// Depends on nothing; divide by 100 is a reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module cct_leap (
  input  wire logic [15:0] year,
  output logic             leap
);

  // floor(y/100) = (y * 83887) >> 23, exact for all 16-bit y
  localparam logic [16:0] RECIP_100   = 17'd83887;
  localparam int          RECIP_SHIFT = 23;

  logic [32:0] prod;
  logic [9:0]  quot;
  logic [15:0] quot_x100;
  logic        div100;

  assign prod      = {17'd0, year} * {16'd0, RECIP_100};
  assign quot      = prod[RECIP_SHIFT +: 10];
  assign quot_x100 = {quot, 6'd0} + {1'b0, quot, 5'd0} + {4'd0, quot, 2'd0};
  assign div100    = (quot_x100 == year);
  // divisible by 400: divisible by 100 and quotient divisible by 4
  assign leap      = (year[1:0] == 2'd0) && (!div100 || (quot[1:0] == 2'd0));

endmodule

`default_nettype wire

@@ hw/rtl/cct_step.sv @@
// Next-state logic: one-second carry chain or validated load.
// Uses cct_pkg and cct_leap.
`timescale 1ns / 1ps
`default_nettype none

module cct_step (
  input  wire cct_pkg::cal_t  cal,
  input  wire cct_pkg::item_t item,
  output cct_pkg::cal_t       cal_next,
  output logic                rejected
);

  import cct_pkg::*;

  logic        is_load;
  logic [15:0] year_sel;
  logic [3:0]  month_sel;
  logic        leap;
  logic [4:0]  mlen;
  logic        load_ok;
  logic        c_sec, c_min, c_hour, c_day, c_month;
  cal_t        ticked;

  assign is_load   = (item.action == ACT_LOAD);
  assign year_sel  = is_load ? item.load_year  : cal.year;
  assign month_sel = is_load ? item.load_month : cal.month;

  cct_leap u_leap (
    .year (year_sel),
    .leap (leap)
  );

  assign mlen = month_len(month_sel, leap);

  assign load_ok = (item.load_month >= MONTH_MIN) && (item.load_month <= MONTH_MAX) &&
                   (item.load_day >= DAY_MIN) && (item.load_day <= mlen) &&
                   (item.load_hour <= HOUR_MAX) && (item.load_minute <= MIN_MAX) &&
                   (item.load_second <= SEC_MAX);

  assign c_sec   = (cal.second >= SEC_MAX);
  assign c_min   = c_sec  && (cal.minute >= MIN_MAX);
  assign c_hour  = c_min  && (cal.hour >= HOUR_MAX);
  assign c_day   = c_hour && (cal.day >= mlen);
  assign c_month = c_day  && (cal.month >= MONTH_MAX);

  always_comb begin
    ticked.second = c_sec   ? 6'd0      : cal.second + 6'd1;
    ticked.minute = !c_sec  ? cal.minute : (c_min   ? 6'd0      : cal.minute + 6'd1);
    ticked.hour   = !c_min  ? cal.hour   : (c_hour  ? 5'd0      : cal.hour + 5'd1);
    ticked.day    = !c_hour ? cal.day    : (c_day   ? DAY_MIN   : cal.day + 5'd1);
    ticked.month  = !c_day  ? cal.month  : (c_month ? MONTH_MIN : cal.month + 4'd1);
    ticked.year   = c_month ? cal.year + 16'd1 : cal.year;
  end

  always_comb begin
    cal_next = cal;
    rejected = 1'b0;
    if (!is_load) begin
      cal_next = ticked;
    end else if (load_ok) begin
      cal_next.year   = item.load_year;
      cal_next.month  = item.load_month;
      cal_next.day    = item.load_day;
      cal_next.hour   = item.load_hour;
      cal_next.minute = item.load_minute;
      cal_next.second = item.load_second;
    end else begin
      rejected = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/calendar_clock_tick.sv @@
// Calendar clock top level: input register, calendar state, result register.
// Uses cct_pkg and cct_step.
// Items go from the input register through one cct_step pass to the result register.
// Throughput: one transaction per cycle while no result is held by result_stall.
// Reset (rst, synchronous): 31 Dec 2017 00:00:00, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_tick (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire cct_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output cct_pkg::result_t      result
);

  import cct_pkg::*;

  logic  s1_valid;
  item_t s1_item;
  cal_t  cal;
  cal_t  cal_next;
  logic  step_rejected;
  logic  advance;
  logic  accept;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign accept     = item_valid && !item_stall;

  cct_step u_step (
    .cal      (cal),
    .item     (s1_item),
    .cal_next (cal_next),
    .rejected (step_rejected)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal.year   <= YEAR_RST;
      cal.month  <= MONTH_RST;
      cal.day    <= DAY_RST;
      cal.hour   <= 5'd0;
      cal.minute <= 6'd0;
      cal.second <= 6'd0;
    end else if (s1_valid && advance) begin
      cal <= cal_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      result.cur_year      <= cal_next.year;
      result.cur_month     <= cal_next.month;
      result.cur_day       <= cal_next.day;
      result.cur_hour      <= cal_next.hour;
      result.cur_minute    <= cal_next.minute;
      result.cur_second    <= cal_next.second;
      result.load_rejected <= step_rejected;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_tick_not_rejected: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && s1_item.action == ACT_TICK) |=> !result.load_rejected)
    else $error("tick reported as rejected load");

  a_reject_holds_cal: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && step_rejected) |=> $stable(cal))
    else $error("rejected load changed the calendar");

  a_tick_second_only: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && s1_item.action == ACT_TICK && cal.second != SEC_MAX)
    |=> (cal.second == $past(cal.second) + 6'd1) && (cal.minute == $past(cal.minute)))
    else $error("tick without carry altered more than the seconds");
`endif

endmodule

`default_nettype wire
